@@ design/tia_pkg.sv @@
// shared types, codes and constants for the tagged integer alu
package tia_pkg;

  localparam int WordW = 64;
  localparam int ValW  = 32;
  localparam int CmdW  = 3;
  localparam int StW   = 3;
  localparam int QueueDepth = 2;
  // quotient bits resolved per divide stage, and the stage count that follows
  localparam int DivBits   = 2;
  localparam int DivStages = ValW / DivBits;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_EQ   = 3'd4,
    CMD_LT   = 3'd5,
    CMD_LE   = 3'd6,
    CMD_NOP  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_A_TYPE = 3'd1,
    ST_B_TYPE = 3'd2,
    ST_OVER   = 3'd3,
    ST_UNDER  = 3'd4,
    ST_DIV0   = 3'd5
  } status_t;

  localparam logic [2:0]  TagMask   = 3'd7;
  localparam logic [2:0]  TagInt    = 3'd2;
  localparam logic [63:0] WordTrue  = 64'd31;
  localparam logic [63:0] WordFalse = 64'd15;

  // classified item handed from front to back
  typedef struct packed {
    cmd_t               cmd;
    logic               pre_err;   // status already settled by the front
    status_t            pre_st;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } op_t;

  // item as it travels down the back pipeline
  typedef struct packed {
    op_t                op;
    logic signed [64:0] r;     // add, sub and mul result
    logic               cmp;   // compare outcome
    logic               neg;   // quotient sign
    logic [ValW-1:0]    rem;   // partial remainder
    logic [ValW-1:0]    quo;   // dividend shifting out, quotient shifting in
    logic [ValW-1:0]    dvs;   // divisor magnitude
  } exe_t;

endpackage

@@ design/tia_front.sv @@
// front end: tag checks, divide by zero check and operand decode
module tia_front import tia_pkg::*; (
  input  logic [CmdW-1:0]  cmd,
  input  logic [WordW-1:0] a,
  input  logic [WordW-1:0] b,
  output op_t              op
);

  // classify the item
  always_comb begin
    op.cmd     = cmd_t'(cmd);
    op.x       = a[63:32];
    op.y       = b[63:32];
    op.pre_err = 1'b0;
    op.pre_st  = ST_OK;
    if (cmd_t'(cmd) == CMD_NOP) begin
      op.pre_err = 1'b1;
    end else if ((a[2:0] & TagMask) != TagInt) begin
      op.pre_err = 1'b1;
      op.pre_st  = ST_A_TYPE;
    end else if ((b[2:0] & TagMask) != TagInt) begin
      op.pre_err = 1'b1;
      op.pre_st  = ST_B_TYPE;
    end else if (cmd_t'(cmd) == CMD_DIV && b[63:32] == '0) begin
      op.pre_err = 1'b1;
      op.pre_st  = ST_DIV0;
    end
  end

endmodule

@@ design/tia_queue.sv @@
// small fifo between front and back
module tia_queue import tia_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  op_t  in_op,
  output logic out_valid,
  input  logic out_ready,
  output op_t  out_op
);

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  op_t mem_r [Depth];
  logic [Aw-1:0] wp_r, rp_r;
  logic [Aw:0]   cnt_r;
  logic wr, rd;

  assign in_ready  = cnt_r != (Aw+1)'(Depth);
  assign out_valid = cnt_r != '0;
  assign out_op    = mem_r[rp_r];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= in_op;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == Aw'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == Aw'(Depth-1)) ? '0 : rp_r + 1'b1;
      if (wr && !rd) cnt_r <= cnt_r + 1'b1;
      else if (rd && !wr) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Aw+1)'(Depth)) else $error("queue count overrun");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count not raised");
  a_cnt_dn: assert property (@(posedge clk) disable iff (!rst_n)
    rd && !wr |=> cnt_r == $past(cnt_r) - 1'b1) else $error("count not lowered");

endmodule

@@ design/tia_back.sv @@
// back end: entry stage, pipelined divide stages and output register
module tia_back import tia_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  op_t              in_op,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_word,
  output logic [StW-1:0]   out_st
);

  // pipeline regs, entry stage then one per divide step
  exe_t               s_r [DivStages+1];
  logic [DivStages:0] v_r;
  logic [DivStages:0] adv;
  // output regs
  logic               v2_r;
  logic [WordW-1:0]   w2_r;
  logic [StW-1:0]     s2_r;

  logic                    adv2;
  exe_t                    e_nxt;
  logic signed [2*ValW-1:0] prod;
  exe_t                    lst;
  logic signed [64:0]      r_fin;
  logic [WordW-1:0]        w_nxt;
  logic [StW-1:0]          s_nxt;

  // a few quotient bits by restoring division
  function automatic exe_t div_step(exe_t s);
    exe_t            t;
    logic [ValW-1:0] sh;
    t = s;
    for (int i = 0; i < DivBits; i++) begin
      sh    = {t.rem[ValW-2:0], t.quo[ValW-1]};
      t.quo = {t.quo[ValW-2:0], 1'b0};
      if (sh >= t.dvs) begin
        t.rem    = sh - t.dvs;
        t.quo[0] = 1'b1;
      end else begin
        t.rem = sh;
      end
    end
    return t;
  endfunction

  // advance chain, bubbles collapse toward the output
  assign adv2 = !v2_r || out_ready;
  always_comb begin
    adv[DivStages] = !v_r[DivStages] || adv2;
    for (int k = DivStages - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end
  assign in_ready = adv[0];

  // entry: add, sub, mul and compares, divide operands as magnitudes
  always_comb begin
    e_nxt     = '0;
    e_nxt.op  = in_op;
    prod      = in_op.x * in_op.y;
    e_nxt.quo = in_op.x[ValW-1] ? $unsigned(-in_op.x) : $unsigned(in_op.x);
    e_nxt.dvs = in_op.y[ValW-1] ? $unsigned(-in_op.y) : $unsigned(in_op.y);
    e_nxt.neg = in_op.x[ValW-1] ^ in_op.y[ValW-1];
    case (in_op.cmd)
      CMD_ADD: e_nxt.r = 65'(in_op.x) + 65'(in_op.y);
      CMD_SUB: e_nxt.r = 65'(in_op.x) - 65'(in_op.y);
      CMD_MUL: e_nxt.r = 65'(prod);
      CMD_EQ:  e_nxt.cmp = in_op.x == in_op.y;
      CMD_LT:  e_nxt.cmp = in_op.x <  in_op.y;
      CMD_LE:  e_nxt.cmp = in_op.x <= in_op.y;
      default: e_nxt.r = '0;
    endcase
  end

  // pipeline data
  always_ff @(posedge clk) begin
    if (adv[0]) s_r[0] <= e_nxt;
    for (int k = 1; k <= DivStages; k++) begin
      if (adv[k]) s_r[k] <= div_step(s_r[k-1]);
    end
  end

  assign lst = s_r[DivStages];

  // quotient sign, range check and result formatting
  always_comb begin
    r_fin = lst.r;
    if (lst.op.cmd == CMD_DIV) begin
      r_fin = lst.neg ? -$signed(65'(lst.quo)) : $signed(65'(lst.quo));
    end
    w_nxt = '0;
    s_nxt = ST_OK;
    if (lst.op.pre_err) begin
      s_nxt = lst.op.pre_st;
    end else begin
      case (lst.op.cmd)
        CMD_EQ, CMD_LT, CMD_LE: w_nxt = lst.cmp ? WordTrue : WordFalse;
        default: begin
          if (r_fin > 65'sd2147483647) s_nxt = ST_OVER;
          else if (r_fin < -65'sd2147483648) s_nxt = ST_UNDER;
          else w_nxt = {r_fin[31:0], 29'd0, TagInt};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      w2_r <= w_nxt;
      s2_r <= s_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0; v2_r <= 1'b0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k <= DivStages; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
      if (adv2) v2_r <= v_r[DivStages];
    end
  end

  assign out_valid = v2_r;
  assign out_word  = w2_r;
  assign out_st    = s2_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && s2_r != ST_OK |-> w2_r == '0) else $error("error with nonzero word");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !out_ready |=> v2_r && $stable(w2_r)) else $error("result lost");
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DivStages] && adv2 |=> v2_r) else $error("stage item dropped");

endmodule

@@ design/tagged_int_alu_unit.sv @@
// top level of the tagged integer alu
// Items come in on in_cmd/in_operand_a/in_operand_b with in_valid/in_ready
// and leave on out_result_word/out_status with out_valid/out_ready.
// The front checks both tags and divide by zero, the item then waits in a
// two entry queue, the back computes add, sub, mul and compares in an entry
// stage and runs a divide over sixteen stages of two quotient bits each;
// every item walks the same stages so order is kept.
// When nothing stalls, an accepted item passes the queue, the entry stage,
// the 16 divide stages and the output register, then shows on out_valid.
// Throughput: one item per cycle unless the receiver stalls the output.
// Every item gives exactly one result, in order.
// Reset (rst_n low, synchronous) empties the queue and all back stages.
// When the receiver stalls the output register holds, the back stages fill,
// then the queue, and in_ready falls once the queue is full; nothing is lost.
module tagged_int_alu_unit import tia_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CmdW-1:0]  in_cmd,
  input  logic [WordW-1:0] in_operand_a,
  input  logic [WordW-1:0] in_operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_result_word,
  output logic [StW-1:0]   out_status
);

  op_t  f_op, q_op;
  logic q_valid, q_ready;

  tia_front u_front (.cmd(in_cmd), .a(in_operand_a), .b(in_operand_b), .op(f_op));

  tia_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst_n, .in_valid, .in_ready, .in_op(f_op),
    .out_valid(q_valid), .out_ready(q_ready), .out_op(q_op)
  );

  tia_back u_back (
    .clk, .rst_n, .in_valid(q_valid), .in_ready(q_ready), .in_op(q_op),
    .out_valid, .out_ready, .out_word(out_result_word), .out_st(out_status)
  );

endmodule

@@ dv/tagged_int_alu_unit_tb.sv @@
// self-checking testbench for the tagged integer alu
module tagged_int_alu_unit_tb;
  import tia_pkg::*;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  st;
  } alu_res_t;

  // expected result queue and comparison of returned items
  class alu_scoreboard;
    alu_res_t pending[$];
    int       mismatches;

    function automatic alu_res_t compute(logic [2:0] cmd, logic [63:0] a, logic [63:0] b);
      alu_res_t    res;
      longint      x, y, r;
      bit          arith;
      res.word = '0;
      res.st   = ST_OK;
      arith    = 1'b0;
      r        = 0;
      if (cmd == CMD_NOP) return res;
      if (a[2:0] != TagInt) res.st = ST_A_TYPE;
      else if (b[2:0] != TagInt) res.st = ST_B_TYPE;
      else begin
        x = longint'($signed(a[63:32]));
        y = longint'($signed(b[63:32]));
        case (cmd)
          CMD_ADD: begin r = x + y; arith = 1'b1; end
          CMD_SUB: begin r = x - y; arith = 1'b1; end
          CMD_MUL: begin r = x * y; arith = 1'b1; end
          CMD_DIV: begin
            if (y == 0) res.st = ST_DIV0;
            else begin r = x / y; arith = 1'b1; end
          end
          CMD_EQ: res.word = (x == y) ? WordTrue : WordFalse;
          CMD_LT: res.word = (x < y) ? WordTrue : WordFalse;
          default: res.word = (x <= y) ? WordTrue : WordFalse;
        endcase
        if (arith) begin
          if (r > 64'sd2147483647) res.st = ST_OVER;
          else if (r < -64'sd2147483648) res.st = ST_UNDER;
          else res.word = {r[31:0], 29'd0, TagInt};
        end
      end
      if (res.st != ST_OK) res.word = '0;
      return res;
    endfunction

    function void note_item(logic [2:0] cmd, logic [63:0] a, logic [63:0] b);
      pending.push_back(compute(cmd, a, b));
    endfunction

    function void check_result(logic [63:0] word, logic [2:0] st);
      alu_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item word=%h st=%0d", word, st);
        return;
      end
      exp_r = pending.pop_front();
      if (word !== exp_r.word || st !== exp_r.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp word=%h st=%0d got word=%h st=%0d",
                   exp_r.word, exp_r.st, word, st);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_cmd = '0;
  logic [63:0] in_operand_a = '0;
  logic [63:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result_word;
  logic [2:0]  out_status;

  alu_scoreboard sb = new();
  bit            sending_done = 1'b0;
  int            idle_cycles = 0;
  localparam int IdleLimit = 2000;

  always #2 clk = ~clk;

  tagged_int_alu_unit u_dut (.*);

  // random gap length, mostly short with the odd long one
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // tagged integer with random ignored middle bits
  function automatic logic [63:0] mk_int(logic [31:0] v);
    logic [28:0] mid;
    mid = 29'($urandom);
    return {v, mid, TagInt};
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 20)) - 10);
      3: return {{16{1'b0}}, 16'($urandom)} ^ ({32{$urandom_range(0, 1) == 1}});
      default: return 32'($urandom);
    endcase
  endfunction

  // valid stays high into the next item when there is no gap
  task automatic send_item(logic [2:0] cmd, logic [63:0] a, logic [63:0] b);
    int gap;
    in_cmd       <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(cmd, a, b);
    @(negedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random();
    logic [2:0]  cmd;
    logic [63:0] a, b;
    cmd = 3'($urandom_range(0, 7));
    a   = mk_int(rand_val());
    b   = mk_int(rand_val());
    if ($urandom_range(0, 9) == 0) a = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) b = {$urandom, $urandom};
    if (cmd == CMD_DIV && $urandom_range(0, 7) == 0) b = mk_int('0);
    send_item(cmd, a, b);
  endtask

  // stimulus
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed extremes and special cases
    send_item(CMD_ADD, mk_int(32'h7fffffff), mk_int(32'd1));
    send_item(CMD_ADD, mk_int(32'h80000000), mk_int(32'hffffffff));
    send_item(CMD_ADD, mk_int(32'd5), mk_int(32'hfffffffd));
    send_item(CMD_SUB, mk_int(32'h80000000), mk_int(32'd1));
    send_item(CMD_SUB, mk_int(32'h7fffffff), mk_int(32'hffffffff));
    send_item(CMD_SUB, 64'hffffffff_fffffffa, 64'h00000000_0000000a);
    send_item(CMD_MUL, mk_int(32'h80000000), mk_int(32'h80000000));
    send_item(CMD_MUL, mk_int(32'h80000000), mk_int(32'd1));
    send_item(CMD_MUL, mk_int(32'h80000000), mk_int(32'hffffffff));
    send_item(CMD_MUL, mk_int(32'h00010000), mk_int(32'hffff8000));
    send_item(CMD_MUL, mk_int(32'h00010000), mk_int(32'hffff7fff));
    send_item(CMD_DIV, mk_int(32'h80000000), mk_int(32'hffffffff));
    send_item(CMD_DIV, mk_int(32'hfffffff9), mk_int(32'd2));
    send_item(CMD_DIV, mk_int(32'd7), mk_int(32'd0));
    send_item(CMD_DIV, 64'h0, mk_int(32'd0));
    send_item(CMD_ADD, mk_int(32'd1), 64'hffffffff_ffffffff);
    send_item(CMD_EQ, mk_int(32'd3), mk_int(32'd3));
    send_item(CMD_EQ, mk_int(32'd3), mk_int(32'd4));
    send_item(CMD_LT, mk_int(32'h80000000), mk_int(32'h7fffffff));
    send_item(CMD_LT, mk_int(32'd4), mk_int(32'd4));
    send_item(CMD_LE, mk_int(32'd4), mk_int(32'd4));
    send_item(CMD_LE, mk_int(32'd5), mk_int(32'd4));
    send_item(CMD_NOP, 64'hffffffff_ffffffff, 64'h1);
    send_item(CMD_NOP, 64'h0, 64'h0);
    // hold off until the pipeline drains
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    for (int i = 0; i < 550; i++) begin
      send_random();
      if (i == 275) begin
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver stalls
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_result_word, out_status);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IdleLimit || (sending_done && sb.pending.size() == 0));
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
    end else begin
      repeat (20) @(posedge clk);
      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("tb: success");
      else $display("tb: failure");
    end
    $finish;
  end

endmodule
